@@ hw/rtl/qrm_pkg.sv @@
// Shared constants for the quaternion to rotation matrix pipeline.
package qrm_pkg;
  localparam int FRAC_BITS = 14;
  localparam int CW = 16;
  localparam int PW = 2 * CW;
  localparam int NW = PW + 3;
  localparam int SW = PW + 1;
  localparam int MW = PW + 1;
  localparam int DW = SW + 1;
  localparam int QW = FRAC_BITS + 1;
  localparam int RW = MW + FRAC_BITS + 2;
  localparam int LAT = QW + 5;
  localparam logic signed [CW-1:0] ONE =
    ((1 << FRAC_BITS) > 32767) ? CW'(32767) : CW'(1 << FRAC_BITS);
endpackage

@@ hw/rtl/quaternion_to_rotation_matrix.sv @@
// Top level: quaternion in, normalized 3x3 rotation matrix out, fully pipelined.
// Takes one quaternion every cycle (busy is always low) and returns its matrix
// with done high; the matrix comes from a restoring divider, one quotient bit
// per stage across 15 stages, after input, product and sum stages. Entries are
// Q1.14 rounded to nearest, ties away from zero. A zero quaternion yields the
// identity with zero_norm set.
module quaternion_to_rotation_matrix (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [qrm_pkg::CW-1:0] comp_w,
  input  logic signed [qrm_pkg::CW-1:0] comp_x,
  input  logic signed [qrm_pkg::CW-1:0] comp_y,
  input  logic signed [qrm_pkg::CW-1:0] comp_z,
  output logic                          done,
  output logic signed [qrm_pkg::CW-1:0] r00,
  output logic signed [qrm_pkg::CW-1:0] r01,
  output logic signed [qrm_pkg::CW-1:0] r02,
  output logic signed [qrm_pkg::CW-1:0] r10,
  output logic signed [qrm_pkg::CW-1:0] r11,
  output logic signed [qrm_pkg::CW-1:0] r12,
  output logic signed [qrm_pkg::CW-1:0] r20,
  output logic signed [qrm_pkg::CW-1:0] r21,
  output logic signed [qrm_pkg::CW-1:0] r22,
  output logic                          zero_norm
);
  import qrm_pkg::*;

  logic                 vld [0:LAT-1];
  logic                 zr  [2:LAT-1];
  logic signed [CW-1:0] w, x, y, z;
  logic signed [PW-1:0] ww, xx, yy, zz, xy, xz, xw, yz, yw, zw;
  logic signed [NW-1:0] num [0:8];
  logic [SW-1:0]        s;
  logic [SW-1:0]        ssum;
  logic [QW-1:0]        q   [0:8];
  logic                 ng  [0:8];
  logic signed [CW-1:0] res [0:8];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) vld[i] <= 1'b0;
    end else begin
      vld[0] <= start & ~busy;
      for (int i = 1; i < LAT; i++) vld[i] <= vld[i-1];
    end
  end

  assign ssum = SW'(ww) + SW'(xx) + SW'(yy) + SW'(zz);

  always_ff @(posedge clk) begin
    w <= comp_w;
    x <= comp_x;
    y <= comp_y;
    z <= comp_z;
    ww <= w * w;
    xx <= x * x;
    yy <= y * y;
    zz <= z * z;
    xy <= x * y;
    xz <= x * z;
    xw <= x * w;
    yz <= y * z;
    yw <= y * w;
    zw <= z * w;
    s <= ssum;
    zr[2] <= (ssum == '0);
    for (int i = 3; i < LAT; i++) zr[i] <= zr[i-1];
    num[0] <= NW'(ww) + NW'(xx) - NW'(yy) - NW'(zz);
    num[1] <= (NW'(xy) - NW'(zw)) <<< 1;
    num[2] <= (NW'(xz) + NW'(yw)) <<< 1;
    num[3] <= (NW'(xy) + NW'(zw)) <<< 1;
    num[4] <= NW'(ww) - NW'(xx) + NW'(yy) - NW'(zz);
    num[5] <= (NW'(yz) - NW'(xw)) <<< 1;
    num[6] <= (NW'(xz) - NW'(yw)) <<< 1;
    num[7] <= (NW'(yz) + NW'(xw)) <<< 1;
    num[8] <= NW'(ww) - NW'(xx) - NW'(yy) + NW'(zz);
  end

  for (genvar k = 0; k < 9; k++) begin : g_lane
    logic signed [CW-1:0] mq;
    qrm_div u_div (
      .clk (clk),
      .num (num[k]),
      .s   (s),
      .quo (q[k]),
      .neg (ng[k])
    );
    assign mq = ($signed({1'b0, q[k]}) > ONE) ? ONE : CW'($signed({1'b0, q[k]}));
    always_ff @(posedge clk) begin
      if (zr[LAT-2]) begin
        res[k] <= (k == 0 || k == 4 || k == 8) ? ONE : '0;
      end else begin
        res[k] <= ng[k] ? -mq : mq;
      end
    end
  end

  assign done      = vld[LAT-1];
  assign zero_norm = zr[LAT-1];
  assign r00 = res[0];
  assign r01 = res[1];
  assign r02 = res[2];
  assign r10 = res[3];
  assign r11 = res[4];
  assign r12 = res[5];
  assign r20 = res[6];
  assign r21 = res[7];
  assign r22 = res[8];

  a_zero_diag: assert property (@(posedge clk) disable iff (rst)
    done && zero_norm |-> r00 == ONE && r11 == ONE && r22 == ONE)
    else $error("identity diagonal wrong on zero quaternion");
  a_zero_off: assert property (@(posedge clk) disable iff (rst)
    done && zero_norm |-> r01 == 0 && r12 == 0 && r20 == 0)
    else $error("identity off-diagonal wrong on zero quaternion");
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> r00 <= ONE && r00 >= -ONE && r12 <= ONE && r12 >= -ONE)
    else $error("matrix entry outside unit range");
endmodule

@@ hw/rtl/qrm_div.sv @@
// One divider lane: rounded magnitude of num * 2^FRAC_BITS / s, one quotient bit per stage.
module qrm_div (
  input  logic                          clk,
  input  logic signed [qrm_pkg::NW-1:0] num,
  input  logic [qrm_pkg::SW-1:0]        s,
  output logic [qrm_pkg::QW-1:0]        quo,
  output logic                          neg
);
  import qrm_pkg::*;

  logic [RW-1:0] rem  [0:QW];
  logic [DW-1:0] den  [0:QW];
  logic [QW-1:0] qacc [0:QW];
  logic          sgn  [0:QW];
  logic [MW-1:0] mag;
  logic signed [NW-1:0] nneg;

  assign nneg = -num;
  assign mag  = num[NW-1] ? MW'(nneg) : MW'(num);

  always_ff @(posedge clk) begin
    rem[0]  <= RW'({mag, {(FRAC_BITS+1){1'b0}}}) + RW'(s);
    den[0]  <= {s, 1'b0};
    qacc[0] <= '0;
    sgn[0]  <= num[NW-1];
  end

  for (genvar i = 0; i < QW; i++) begin : g_stage
    localparam int B = QW - 1 - i;
    logic [RW:0] trial;
    assign trial = {1'b0, rem[i]} - ({1'b0, RW'(den[i])} << B);
    always_ff @(posedge clk) begin
      den[i+1] <= den[i];
      sgn[i+1] <= sgn[i];
      if (!trial[RW]) begin
        rem[i+1]  <= trial[RW-1:0];
        qacc[i+1] <= {qacc[i][QW-2:0], 1'b1};
      end else begin
        rem[i+1]  <= rem[i];
        qacc[i+1] <= {qacc[i][QW-2:0], 1'b0};
      end
    end
  end

  assign quo = qacc[QW];
  assign neg = sgn[QW];
endmodule

@@ tb/tb_quaternion_to_rotation_matrix.sv @@
// Testbench for the quaternion to rotation matrix block: random and corner beats, checked by a scoreboard.
`timescale 1ns / 100ps

module tb_quaternion_to_rotation_matrix;
  import qrm_pkg::*;

  typedef struct {
    logic signed [CW-1:0] m [9];
    logic                 zn;
  } matrix_t;

  class matrix_board;
    matrix_t pending[$];
    int      errors;

    function logic signed [CW-1:0] round_div(longint num, longint s);
      longint mag, q, lim_p, lim_n;
      mag = (num < 0) ? -num : num;
      q = ((mag <<< (FRAC_BITS + 1)) + s) / (2 * s);
      if (q > (64'sd1 <<< 40)) q = 64'sd1 <<< 40;
      if (num < 0) q = -q;
      lim_p = 64'sd1 <<< FRAC_BITS;
      lim_n = -lim_p;
      if (lim_p > 32767) lim_p = 32767;
      if (lim_n < -32768) lim_n = -32768;
      if (q > lim_p) q = lim_p;
      if (q < lim_n) q = lim_n;
      return q[CW-1:0];
    endfunction

    function void note_quat(logic signed [CW-1:0] qw, qx, qy, qz);
      longint w, x, y, z, s;
      longint n [9];
      matrix_t e;
      w = qw; x = qx; y = qy; z = qz;
      s = w*w + x*x + y*y + z*z;
      n[0] = w*w + x*x - y*y - z*z;
      n[1] = 2 * (x*y - z*w);
      n[2] = 2 * (x*z + y*w);
      n[3] = 2 * (x*y + z*w);
      n[4] = w*w - x*x + y*y - z*z;
      n[5] = 2 * (y*z - x*w);
      n[6] = 2 * (x*z - y*w);
      n[7] = 2 * (y*z + x*w);
      n[8] = w*w - x*x - y*y + z*z;
      if (s == 0) begin
        foreach (e.m[i]) e.m[i] = '0;
        e.m[0] = ONE; e.m[4] = ONE; e.m[8] = ONE;
        e.zn = 1'b1;
      end else begin
        foreach (e.m[i]) e.m[i] = round_div(n[i], s);
        e.zn = 1'b0;
      end
      pending.push_back(e);
    endfunction

    function void check_matrix(matrix_t got);
      matrix_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat", $realtime);
        errors++;
        return;
      end
      e = pending.pop_front();
      foreach (e.m[i])
        if (got.m[i] !== e.m[i]) begin
          $display("%0t: entry %0d expected %0d actual %0d", $realtime, i, e.m[i], got.m[i]);
          errors++;
        end
      if (got.zn !== e.zn) begin
        $display("%0t: zero_norm expected %0b actual %0b", $realtime, e.zn, got.zn);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done, zero_norm;
  logic signed [CW-1:0] comp_w = '0, comp_x = '0, comp_y = '0, comp_z = '0;
  logic signed [CW-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  matrix_board board;
  longint cycles = 0;

  always #10 clk = ~clk;

  quaternion_to_rotation_matrix DUT (.*);

  always @(posedge clk) begin
    matrix_t got;
    cycles <= cycles + 1;
    if (!rst && done) begin
      got.m = '{r00, r01, r02, r10, r11, r12, r20, r21, r22};
      got.zn = zero_norm;
      board.check_matrix(got);
    end
    if (cycles > 200000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_quat(logic signed [CW-1:0] w, x, y, z);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    comp_w <= w; comp_x <= x; comp_y <= y; comp_z <= z;
    do @(posedge clk); while (busy);
    board.note_quat(w, x, y, z);
    @(negedge clk);
  endtask

  function automatic logic signed [CW-1:0] pick_comp();
    case ($urandom_range(0, 5))
      0: return CW'($signed(-32768));
      1: return CW'(32767);
      2: return '0;
      3: return CW'($signed($urandom_range(0, 32)) - 16);
      default: return CW'($urandom);
    endcase
  endfunction

  initial begin
    board = new();
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_quat(0, 0, 0, 0);
    send_quat(16384, 0, 0, 0);
    send_quat(-16384, 0, 0, 0);
    send_quat(0, 16384, 0, 0);
    send_quat(0, 0, 16384, 0);
    send_quat(0, 0, 0, 16384);
    send_quat(-32768, -32768, -32768, -32768);
    send_quat(32767, 32767, 32767, 32767);
    send_quat(-32768, 32767, -32768, 32767);
    send_quat(0, 0, 0, 1);
    send_quat(1, 0, 0, 0);
    send_quat(-1, 1, -1, 1);
    send_quat(1, 1, 0, 0);
    send_quat(0, -32768, 0, 0);
    send_quat(8192, 8192, 8192, 8192);
    send_quat(3, -7, 0, 0);
    send_quat(0, 0, 0, 0);
    start <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    for (int i = 0; i < 1100; i++) begin
      if ($urandom_range(0, 1))
        send_quat(CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom));
      else
        send_quat(pick_comp(), pick_comp(), pick_comp(), pick_comp());
    end
    start <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (LAT + 10) @(negedge clk);
    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

@@ files.f @@
hw/rtl/qrm_pkg.sv
hw/rtl/qrm_div.sv
hw/rtl/quaternion_to_rotation_matrix.sv
tb/tb_quaternion_to_rotation_matrix.sv
